// ----- src/lpft_pkg.sv -----
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared constants and types for the LRU page frame table: fixed field
// widths, register map, reset values and the frame memory control bundle.
// ----------------------------------------------------------------------------
package lpft_pkg;

	// Default sizing handed to the top level parameters
	localparam int DEF_MAX_FRAMES = 16;
	localparam int DEF_PAGE_BITS  = 20;
	localparam int DEF_TIME_BITS  = 32;

	// Fixed field widths
	localparam int ADDR_W      = 32;
	localparam int COUNT_W     = 32;
	localparam int IDX_OUT_W   = 4;
	localparam int CFG_W       = 5;
	localparam int OUT_BITS    = IDX_OUT_W + 2 * COUNT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Configuration port
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;

	// Register indexes (paddr[2])
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

	// Frame memory access strobes
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

// ----- src/lpft_frame_mem.sv -----
// ----------------------------------------------------------------------------
// lpft_frame_mem
// Synchronous frame store: one read port and one write port with a registered
// read. Valid bits live in flops so reset empties the table at once.
// ----------------------------------------------------------------------------
module lpft_frame_mem #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4,
	parameter int ENT_W = 85
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lpft_pkg::mem_ctl_t ctl,
	input  logic [IDX_W-1:0]   rd_addr,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [ENT_W-1:0]   wr_data,
	output logic [ENT_W-1:0]   rd_data,
	output logic               rd_valid
);
	import lpft_pkg::*;

	logic [ENT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [ENT_W-1:0] rd_data_q;
	logic             rd_valid_q;

	// Entry storage, registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Valid bits: set on fill, read alongside the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

// ----- src/lpft_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpft_ctrl
// Access sequencer: sweeps the managed frames through the frame memory,
// finds the hit, the first empty frame and the oldest frame, writes the
// chosen frame back, counts hits and misses and holds the result register.
// ----------------------------------------------------------------------------
module lpft_ctrl #(
	parameter int PAGE_BITS  = 20,
	parameter int TIME_BITS  = 32,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5,
	parameter int ENT_W      = 85
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// access transaction
	input  logic                             start,
	output logic                             idle,
	input  logic [PAGE_BITS-1:0]             page,
	input  logic [lpft_pkg::ADDR_W-1:0]      addr,
	input  logic                             is_write,
	input  logic [TIME_BITS-1:0]             stamp,
	input  logic [CNT_W-1:0]                 frame_count,
	// frame memory
	output lpft_pkg::mem_ctl_t               mem_ctl,
	output logic [IDX_W-1:0]                 mem_rd_addr,
	output logic [IDX_W-1:0]                 mem_wr_addr,
	output logic [ENT_W-1:0]                 mem_wr_data,
	input  logic [ENT_W-1:0]                 mem_rd_data,
	input  logic                             mem_rd_valid,
	// result
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             out_hit,
	output logic [lpft_pkg::IDX_OUT_W-1:0]   out_index,
	output logic [lpft_pkg::COUNT_W-1:0]     out_hits,
	output logic [lpft_pkg::COUNT_W-1:0]     out_misses
);
	import lpft_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;

	// Latched access
	logic [PAGE_BITS-1:0] page_q;
	logic [ADDR_W-1:0]    addr_q;
	logic                 wr_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic [CNT_W-1:0]     count_q;

	// Sweep issue and compare stage
	logic [CNT_W-1:0] iss_q;
	logic             cmp_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;

	// Search trackers
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic                 empty_q;
	logic [IDX_W-1:0]     empty_idx_q;
	logic                 old_found_q;
	logic [TIME_BITS-1:0] old_time_q;
	logic [IDX_W-1:0]     old_idx_q;

	// Counters and result register
	logic [COUNT_W-1:0]   hits_q;
	logic [COUNT_W-1:0]   misses_q;
	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [IDX_OUT_W-1:0] out_index_q;

	logic                 issue;
	logic                 out_free;
	logic                 commit;
	logic [IDX_W-1:0]     slot;
	logic [IDX_W+3:0]     slot_ext;
	logic [PAGE_BITS-1:0] ent_page;
	logic [TIME_BITS-1:0] ent_time;
	logic [COUNT_W-1:0]   hits_nxt;
	logic [COUNT_W-1:0]   misses_nxt;

	// Read one frame per cycle until every managed frame is issued
	assign issue       = (state_q == ST_SCAN) && (iss_q < count_q);
	assign mem_rd_addr = iss_q[IDX_W-1:0];

	assign ent_page = mem_rd_data[PAGE_BITS-1:0];
	assign ent_time = mem_rd_data[PAGE_BITS +: TIME_BITS];

	// Pick the frame: hit, else first empty, else oldest
	always_comb begin
		if (hit_q) begin
			slot = hit_idx_q;
		end else if (empty_q) begin
			slot = empty_idx_q;
		end else begin
			slot = old_idx_q;
		end
	end

	assign slot_ext   = {4'b0000, slot};
	assign out_free   = !out_valid_q || out_ready;
	assign commit     = (state_q == ST_COMMIT) && out_free;
	assign hits_nxt   = hits_q + COUNT_W'(hit_q);
	assign misses_nxt = misses_q + COUNT_W'(!hit_q);

	// Write back the chosen frame; the next sweep starts only after this
	assign mem_ctl.rd_en = issue;
	assign mem_ctl.wr_en = commit;
	assign mem_wr_addr   = slot;
	assign mem_wr_data   = {wr_q, addr_q, stamp_q, page_q};

	// Latch the access on acceptance
	always_ff @(posedge clk) begin
		if (start) begin
			page_q  <= page;
			addr_q  <= addr;
			wr_q    <= is_write;
			stamp_q <= stamp;
			count_q <= frame_count;
		end
	end

	// Sequencer, search and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			cmp_s1      <= 1'b0;
			last_s1     <= 1'b0;
			idx_s1      <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			empty_q     <= 1'b0;
			empty_idx_q <= '0;
			old_found_q <= 1'b0;
			old_time_q  <= '0;
			old_idx_q   <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_index_q <= '0;
		end else begin
			// Drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && !commit) begin
				out_valid_q <= 1'b0;
			end

			cmp_s1  <= issue;
			last_s1 <= (iss_q == count_q - CNT_W'(1));
			idx_s1  <= iss_q[IDX_W-1:0];

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						iss_q       <= '0;
						hit_q       <= 1'b0;
						empty_q     <= 1'b0;
						old_found_q <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					// Compare the frame read last cycle
					if (cmp_s1) begin
						if (mem_rd_valid && (ent_page == page_q) && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
						end
						if (!mem_rd_valid && !empty_q) begin
							empty_q     <= 1'b1;
							empty_idx_q <= idx_s1;
						end
						if (mem_rd_valid && (!old_found_q || (ent_time < old_time_q))) begin
							old_found_q <= 1'b1;
							old_time_q  <= ent_time;
							old_idx_q   <= idx_s1;
						end
						if (last_s1) begin
							state_q <= ST_COMMIT;
						end
					end
				end
				ST_COMMIT: begin
					// Hold until the result register is free
					if (out_free) begin
						hits_q      <= hits_nxt;
						misses_q    <= misses_nxt;
						out_valid_q <= 1'b1;
						out_hit_q   <= hit_q;
						out_index_q <= slot_ext[IDX_OUT_W-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle       = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_hit    = out_hit_q;
	assign out_index  = out_index_q;
	assign out_hits   = hits_q;
	assign out_misses = misses_q;

endmodule

// ----- src/lru_page_frame_table_unit.sv -----
// LRU page frame table. Each access transaction on the slave stream carries a
// page number, an address, a timestamp and a write flag; one result leaves on
// the master stream with the hit flag, the frame that was hit or filled, and
// the running hit and miss counts (both wrap). The frame table sits in a
// synchronous memory that is swept one frame per cycle. Between acceptances an
// access reads each managed frame, compares the last frame read, writes the
// chosen frame back and returns to idle. A result waiting in the output
// register does not block the next access until its write-back.
// frames_in_use (register 0) is clamped to 1..MAX_FRAMES; frames above it
// keep their contents. Write it only while the block is idle.
// ----------------------------------------------------------------------------
// lru_page_frame_table_unit
// Top level: APB register, stream packing and the frame memory with its
// access sequencer.
// ----------------------------------------------------------------------------
module lru_page_frame_table_unit #(
	parameter int MAX_FRAMES = lpft_pkg::DEF_MAX_FRAMES,
	parameter int PAGE_BITS  = lpft_pkg::DEF_PAGE_BITS,
	parameter int TIME_BITS  = lpft_pkg::DEF_TIME_BITS,
	localparam int IN_BITS   = PAGE_BITS + lpft_pkg::ADDR_W + TIME_BITS,
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lpft_pkg::PADDR_W-1:0]      paddr,
	input  logic [lpft_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lpft_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	// access stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [IN_W-1:0]                   s_tdata,  // page_number, access_address, access_time
	input  logic                              s_tuser,  // is_write
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lpft_pkg::OUT_TDATA_W-1:0]  m_tdata,  // frame_index, hit_count, miss_count
	output logic                              m_tuser   // hit
);
	import lpft_pkg::*;

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int ENT_W = PAGE_BITS + TIME_BITS + ADDR_W + 1;
	localparam logic [8:0] MAX_FRAMES_9 = 9'(MAX_FRAMES);

	logic [CFG_W-1:0]     frames_q;
	logic                 cfg_wr;
	logic [8:0]           cfg_ext;
	logic [8:0]           managed;
	logic [CNT_W-1:0]     frame_count;
	logic                 start;
	logic                 idle;
	logic [PAGE_BITS-1:0] in_page;
	logic [ADDR_W-1:0]    in_addr;
	logic [TIME_BITS-1:0] in_time;

	mem_ctl_t             mem_ctl;
	logic [IDX_W-1:0]     mem_rd_addr;
	logic [IDX_W-1:0]     mem_wr_addr;
	logic [ENT_W-1:0]     mem_wr_data;
	logic [ENT_W-1:0]     mem_rd_data;
	logic                 mem_rd_valid;

	logic                 out_hit;
	logic [IDX_OUT_W-1:0] out_index;
	logic [COUNT_W-1:0]   out_hits;
	logic [COUNT_W-1:0]   out_misses;

	// Register write and read back
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FRAMES_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_wr) begin
			frames_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ?
		{{(APB_DATA_W - CFG_W){1'b0}}, frames_q} : '0;

	// Clamp the frame count to 1..MAX_FRAMES
	assign cfg_ext = 9'(frames_q);
	always_comb begin
		if (frames_q == '0) begin
			managed = 9'd1;
		end else if (cfg_ext > MAX_FRAMES_9) begin
			managed = MAX_FRAMES_9;
		end else begin
			managed = cfg_ext;
		end
	end
	assign frame_count = managed[CNT_W-1:0];

	// Unpack the access
	assign in_page  = s_tdata[PAGE_BITS-1:0];
	assign in_addr  = s_tdata[PAGE_BITS +: ADDR_W];
	assign in_time  = s_tdata[PAGE_BITS + ADDR_W +: TIME_BITS];
	assign s_tready = idle;
	assign start    = s_tvalid && s_tready;

	lpft_frame_mem #(
		.DEPTH (MAX_FRAMES),
		.IDX_W (IDX_W),
		.ENT_W (ENT_W)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.rd_addr  (mem_rd_addr),
		.wr_addr  (mem_wr_addr),
		.wr_data  (mem_wr_data),
		.rd_data  (mem_rd_data),
		.rd_valid (mem_rd_valid)
	);

	lpft_ctrl #(
		.PAGE_BITS  (PAGE_BITS),
		.TIME_BITS  (TIME_BITS),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W),
		.ENT_W      (ENT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.idle         (idle),
		.page         (in_page),
		.addr         (in_addr),
		.is_write     (s_tuser),
		.stamp        (in_time),
		.frame_count  (frame_count),
		.mem_ctl      (mem_ctl),
		.mem_rd_addr  (mem_rd_addr),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_data  (mem_rd_data),
		.mem_rd_valid (mem_rd_valid),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_hit      (out_hit),
		.out_index    (out_index),
		.out_hits     (out_hits),
		.out_misses   (out_misses)
	);

	// Pack the result
	assign m_tuser = out_hit;
	assign m_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_misses, out_hits, out_index};

endmodule
